[design/kxd_pkg.sv]
// ---------------------------------------------------------------------------
// kxd_pkg
// Shared types, constants and helpers of the keystream XOR descrambler.
// ---------------------------------------------------------------------------
package kxd_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BLK_W     = 25;             // block number width
  localparam int unsigned IDX_W     = 5;              // word position in block
  localparam int unsigned BLK_SHIFT = 7;              // 0x80 bytes per block
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(5'h1f);   // 0x20 words per block

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IV0         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IV1         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IV2         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IV3         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BLOCK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LITTLE_END  = 3'd5;

  typedef struct packed {
    logic [3:0][WORD_W-1:0] iv;
    logic [WORD_W-1:0]      t0;
    logic [WORD_W-1:0]      t1;
    logic [BLK_W-1:0]       start_block;
    logic                   little_endian;
  } cfg_t;

  // item held in the input register
  typedef struct packed {
    logic [WORD_W-1:0] data_word;
    logic              last_word;
    logic              misaligned;
    logic [IDX_W-1:0]  idx;
    logic [BLK_W-1:0]  blk;
  } stage_t;

  function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] v);
    swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

[design/kxd_if.sv]
// ---------------------------------------------------------------------------
// kxd_if
// Valid/ready channels for scrambled input words and descrambled results.
// ---------------------------------------------------------------------------
interface kxd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic        first_word;
  logic        last_word;

  modport source (output valid, data_word, first_word, last_word, input ready);
  modport sink   (input valid, data_word, first_word, last_word, output ready);
endinterface

interface kxd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] plain_word;
  logic        last_out;
  logic        misaligned;

  modport source (output valid, plain_word, last_out, misaligned, input ready);
  modport sink   (input valid, plain_word, last_out, misaligned, output ready);
endinterface

[design/kxd_cfg_regs.sv]
// ---------------------------------------------------------------------------
// kxd_cfg_regs
// Configuration registers plus the t0/t1 key terms derived from them.
// ---------------------------------------------------------------------------
module kxd_cfg_regs
  import kxd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i,
  output cfg_t                 cfg_o
);

  logic [3:0][WORD_W-1:0] iv_q;
  logic [WORD_W-1:0]      t0, t1;
  logic [BLK_W-1:0]       start_block_q;
  logic                   little_endian_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q            <= '0;
      start_block_q   <= '0;
      little_endian_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IV0:         iv_q[0]         <= cfg_wdata_i;
        CFG_IV1:         iv_q[1]         <= cfg_wdata_i;
        CFG_IV2:         iv_q[2]         <= cfg_wdata_i;
        CFG_IV3:         iv_q[3]         <= cfg_wdata_i;
        CFG_START_BLOCK: start_block_q   <= cfg_wdata_i[BLK_W-1:0];
        CFG_LITTLE_END:  little_endian_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // t terms follow the IV words directly, so a write counts for the next key
  assign t0 = iv_q[0] + ~iv_q[2];
  assign t1 = iv_q[1] + ~iv_q[3];

  assign cfg_o.iv            = iv_q;
  assign cfg_o.t0            = t0;
  assign cfg_o.t1            = t1;
  assign cfg_o.start_block   = start_block_q;
  assign cfg_o.little_endian = little_endian_q;

endmodule

[design/kxd_front.sv]
// ---------------------------------------------------------------------------
// kxd_front
// Input register and word/block position tracking.
// ---------------------------------------------------------------------------
module kxd_front
  import kxd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  kxd_in_if.sink           in_if,
  input  logic [BLK_W-1:0] start_block_i,
  input  logic             take_i,      // result stage takes the held item
  output logic             valid_o,
  output stage_t           stage_o
);

  logic             valid_q;
  stage_t           stage_q;
  logic [IDX_W-1:0] idx_q, idx_d, idx_use;
  logic [BLK_W-1:0] blk_q, blk_d, blk_use;
  logic             accept;

  assign in_if.ready = !valid_q || take_i;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    idx_use = in_if.first_word ? '0 : idx_q;
    blk_use = in_if.first_word ? start_block_i : blk_q;
    idx_d   = idx_use + IDX_W'(1);
    blk_d   = blk_use + BLK_W'(idx_use == LAST_IDX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
      blk_q   <= '0;
    end else begin
      if (accept) begin
        valid_q <= 1'b1;
        idx_q   <= idx_d;
        blk_q   <= blk_d;
      end else if (take_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q.data_word  <= in_if.data_word;
      stage_q.last_word  <= in_if.last_word;
      stage_q.misaligned <= in_if.last_word && (idx_use != LAST_IDX);
      stage_q.idx        <= idx_use;
      stage_q.blk        <= blk_use;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

[design/kxd_keyxor.sv]
// ---------------------------------------------------------------------------
// kxd_keyxor
// Key word generation, XOR and the result register.
// ---------------------------------------------------------------------------
module kxd_keyxor
  import kxd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    valid_i,
  input  stage_t  stage_i,
  output logic    take_o,
  kxd_out_if.source out_if
);

  logic              out_valid_q;
  logic [WORD_W-1:0] plain_q;
  logic              last_q, mis_q;

  logic [WORD_W-1:0] t_sel, iv_sel, iv_term, off_n, key, key_ord;
  logic              sub;

  // k = i + 4s + 8j; key - offset = t + (+/-iv) - 1 - offset
  always_comb begin
    case (stage_i.idx[1:0])
      2'd0:    t_sel = cfg_i.t0;
      2'd1:    t_sel = cfg_i.t1;
      2'd2:    t_sel = ~cfg_i.t0;
      default: t_sel = ~cfg_i.t1;
    endcase
    iv_sel  = cfg_i.iv[stage_i.idx[4:3]];
    sub     = stage_i.idx[2];
    iv_term = sub ? ~iv_sel : iv_sel;            // -iv = ~iv + 1
    off_n   = ~{stage_i.blk, {BLK_SHIFT{1'b0}}}; // -1 - offset
    key     = t_sel + iv_term + off_n + WORD_W'(sub);
    key_ord = cfg_i.little_endian ? swap_bytes(key) : key;
  end

  assign take_o = valid_i && (!out_valid_q || out_if.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_if.ready) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      plain_q <= stage_i.data_word ^ key_ord;
      last_q  <= stage_i.last_word;
      mis_q   <= stage_i.misaligned;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.plain_word = plain_q;
  assign out_if.last_out   = last_q;
  assign out_if.misaligned = mis_q;

endmodule

[design/keystream_xor_descrambler.sv]
// ---------------------------------------------------------------------------
// keystream_xor_descrambler
// Descrambles 32-bit words (IV-derived keystream), one per cycle w/o stall.
// ---------------------------------------------------------------------------
// channel   dir  handshake          payload
// in_if     in   valid/ready        data_word[31:0], first_word, last_word
// out_if    out  valid/ready        plain_word[31:0], last_out, misaligned
// cfg       in   cfg_we_i           cfg_idx_i[2:0], cfg_wdata_i[31:0]
//
// From accept to result an item passes the input register, then key
// add/XOR into the result register; one item per cycle unless stalled.
// A stalled output holds the result; the input register still takes a new
// item while it is empty, and both stages back up under a longer stall.
// Reset clears configuration, position (word 0, block 0) and valid flags.
// ---------------------------------------------------------------------------
module keystream_xor_descrambler
  import kxd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i,
  kxd_in_if.sink               in_if,
  kxd_out_if.source            out_if
);

  cfg_t   cfg;
  stage_t stage;
  logic   stage_valid;
  logic   take;

  kxd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  kxd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_if         (in_if),
    .start_block_i (cfg.start_block),
    .take_i        (take),
    .valid_o       (stage_valid),
    .stage_o       (stage)
  );

  kxd_keyxor u_keyxor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (stage_valid),
    .stage_i (stage),
    .take_o  (take),
    .out_if  (out_if)
  );

endmodule
